@@ src/structural_state_step_assert.svh @@
// assertion macros for the structural state step block
`ifndef STRUCTURAL_STATE_STEP_ASSERT_SVH
`define STRUCTURAL_STATE_STEP_ASSERT_SVH
`ifndef SYNTHESIS
`define SSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SSS_ASSERT(lbl, prop, msg)
`define SSS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ src/sss_pkg.sv @@
// shared types and constants of the structural state step block
package sss_pkg;

  localparam int unsigned NormW = 38;
  localparam int unsigned AccW  = 50;

  typedef enum logic [1:0] {
    EV_NORMAL   = 2'd0,
    EV_COLLAPSE = 2'd1,
    EV_ERROR    = 2'd2
  } event_e;

  typedef enum logic [2:0] {
    CFG_ENERGY_GAIN   = 3'd0,
    CFG_MEMORY_GAIN   = 3'd1,
    CFG_ENERGY_DECAY  = 3'd2,
    CFG_MEMORY_DECAY  = 3'd3,
    CFG_RECOVERY_RATE = 3'd4,
    CFG_ENERGY_STRESS = 3'd5,
    CFG_MEMORY_STRESS = 3'd6,
    CFG_STABILITY_MAX = 3'd7
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_C0, ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_C6, ST_C7, ST_C8,
    ST_C9, ST_C10, ST_C11, ST_C12, ST_C13, ST_C14, ST_C15, ST_C16, ST_C17, ST_FIN
  } seq_e;

  typedef struct packed {
    logic             is_load;
    logic             bad_count;
    logic [15:0]      dt;
    logic [NormW-1:0] norm2;
    logic [31:0]      load_energy;
    logic [31:0]      load_memory;
    logic [31:0]      load_stability;
  } cmd_t;

  typedef struct packed {
    logic [23:0] alpha;
    logic [23:0] beta;
    logic [15:0] eta;
    logic [15:0] gamma;
    logic [15:0] rho;
    logic [15:0] lphi;
    logic [15:0] lm;
    logic [31:0] kmax;
  } cfg_t;

  typedef struct packed {
    event_e      ev;
    logic [31:0] energy;
    logic [31:0] memory;
    logic [31:0] stability;
    logic [31:0] steps;
    logic        terminal;
  } res_t;

endpackage

@@ src/structural_state_step.sv @@
// top level of the structural state step block
// Input channel: a queue write side. An item transfers on a clock edge with push high and
// full low. Delta elements are squared and summed in the front end, one element per cycle
// while full is low; a last element or a load becomes a command in a two-entry queue.
// Result channel: a queue read side. The oldest result stands on the result ports while
// empty is low and transfers on an edge with pop high.
// A load, an error or a terminal step is popped from the command queue and answered
// straight into the result register; a full step runs states C0 to C17 and FIN, a chain
// of 15 products through one shared 32x32 multiplier, and holds the back end until FIN
// writes its result, so no new command is taken before the step is through.
// Reset clears energy, memory, stability (terminal until loaded), the step count and the
// partial sum, and loads the configuration reset values. While the receiver stalls, one
// finished result waits in the output register, the back end holds a finished step or
// leaves its next command queued, the queue fills and then full rises; elements without
// the last mark still transfer while the queue has room. Configuration is to be written
// through cfg_we_i, cfg_index_i and cfg_data_i while idle; the block does not enforce it.
module structural_state_step #(
  parameter int VECTOR_LEN  = 8,
  parameter int DELTA_LIMIT = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               push,
  output logic               full,
  input  logic               operation_i,
  input  logic signed [15:0] delta_value_i,
  input  logic               last_element_i,
  input  logic [15:0]        time_step_i,
  input  logic [31:0]        load_energy_i,
  input  logic [31:0]        load_memory_i,
  input  logic [31:0]        load_stability_i,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         event_res_o,
  output logic [31:0]        energy_out_o,
  output logic [31:0]        memory_out_o,
  output logic [31:0]        stability_out_o,
  output logic [31:0]        steps_done_o,
  output logic               terminal_flag_o
);
  import sss_pkg::*;

  `include "structural_state_step_assert.svh"

  cfg_t cfg_q;
  cmd_t cmd_in, cmd_out;
  res_t res;
  logic q_push, q_pop, q_full, q_empty, in_acc;

  assign in_acc = push & ~full;
  assign full   = q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha <= 24'd65536;
      cfg_q.beta  <= 24'd65536;
      cfg_q.eta   <= 16'd655;
      cfg_q.gamma <= 16'd655;
      cfg_q.rho   <= 16'd655;
      cfg_q.lphi  <= 16'd655;
      cfg_q.lm    <= 16'd655;
      cfg_q.kmax  <= 32'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ENERGY_GAIN:   cfg_q.alpha <= cfg_data_i[23:0];
        CFG_MEMORY_GAIN:   cfg_q.beta  <= cfg_data_i[23:0];
        CFG_ENERGY_DECAY:  cfg_q.eta   <= cfg_data_i[15:0];
        CFG_MEMORY_DECAY:  cfg_q.gamma <= cfg_data_i[15:0];
        CFG_RECOVERY_RATE: cfg_q.rho   <= cfg_data_i[15:0];
        CFG_ENERGY_STRESS: cfg_q.lphi  <= cfg_data_i[15:0];
        CFG_MEMORY_STRESS: cfg_q.lm    <= cfg_data_i[15:0];
        CFG_STABILITY_MAX: cfg_q.kmax  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sss_front #(
    .VECTOR_LEN (VECTOR_LEN),
    .DELTA_LIMIT(DELTA_LIMIT)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (in_acc),
    .operation_i     (operation_i),
    .delta_value_i   (delta_value_i),
    .last_element_i  (last_element_i),
    .time_step_i     (time_step_i),
    .load_energy_i   (load_energy_i),
    .load_memory_i   (load_memory_i),
    .load_stability_i(load_stability_i),
    .cmd_push_o      (q_push),
    .cmd_o           (cmd_in)
  );

  sss_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (cmd_in),
    .pop_i  (q_pop),
    .data_o (cmd_out),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  sss_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_i      (cmd_out),
    .cmd_valid_i(~q_empty),
    .cmd_pop_o  (q_pop),
    .res_pop_i  (pop),
    .res_empty_o(empty),
    .res_o      (res)
  );

  assign event_res_o     = res.ev;
  assign energy_out_o    = res.energy;
  assign memory_out_o    = res.memory;
  assign stability_out_o = res.stability;
  assign steps_done_o    = res.steps;
  assign terminal_flag_o = res.terminal;

  `SSS_ASSERT(a_no_push_full, !(q_push && q_full), "command pushed into full queue")
  `SSS_ASSERT(a_term_flag, empty || (terminal_flag_o == (stability_out_o == 32'd0)), "terminal flag mismatch")
  `SSS_ASSERT(a_collapse, empty || (event_res_o != EV_COLLAPSE) || terminal_flag_o, "collapse without zero stability")
  `SSS_ASSERT_NEXT(a_pop_valid, q_pop, 1'b1 && !$past(q_empty), "command popped from empty queue")

endmodule

@@ src/sss_front.sv @@
// front end: squares and sums delta elements, builds step and load commands
module sss_front #(
  parameter int VECTOR_LEN  = 8,
  parameter int DELTA_LIMIT = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic                operation_i,
  input  logic signed [15:0]  delta_value_i,
  input  logic                last_element_i,
  input  logic [15:0]         time_step_i,
  input  logic [31:0]         load_energy_i,
  input  logic [31:0]         load_memory_i,
  input  logic [31:0]         load_stability_i,
  output logic                cmd_push_o,
  output sss_pkg::cmd_t       cmd_o
);
  import sss_pkg::*;

  localparam logic [NormW-1:0] CapSq = NormW'(DELTA_LIMIT * DELTA_LIMIT);

  logic [NormW-1:0] acc_q, acc_d, sum, norm2;
  logic [7:0]       cnt_q, cnt_d, cnt_new;
  logic             ov_q, ov_d, ov_new, cnt_full, bad;
  logic signed [31:0] sq;

  assign sq       = delta_value_i * delta_value_i;
  assign sum      = acc_q + {{(NormW-31){1'b0}}, sq[30:0]};
  assign cnt_full = (cnt_q == 8'hFF);
  assign cnt_new  = cnt_full ? cnt_q : cnt_q + 8'd1;
  assign ov_new   = ov_q | cnt_full;
  assign bad      = ov_new | (cnt_new != 8'(VECTOR_LEN));
  assign norm2    = (DELTA_LIMIT != 0 && sum > CapSq) ? CapSq : sum;

  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    ov_d  = ov_q;
    if (accept_i) begin
      if (operation_i || last_element_i) begin
        acc_d = '0;
        cnt_d = '0;
        ov_d  = 1'b0;
      end else begin
        acc_d = sum;
        cnt_d = cnt_new;
        ov_d  = ov_new;
      end
    end
  end

  assign cmd_push_o           = accept_i & (operation_i | last_element_i);
  assign cmd_o.is_load        = operation_i;
  assign cmd_o.bad_count      = bad;
  assign cmd_o.dt             = time_step_i;
  assign cmd_o.norm2          = norm2;
  assign cmd_o.load_energy    = load_energy_i;
  assign cmd_o.load_memory    = load_memory_i;
  assign cmd_o.load_stability = load_stability_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
      ov_q  <= ov_d;
    end
  end

endmodule

@@ src/sss_cmd_fifo.sv @@
// two-entry command queue between front and back
module sss_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sss_pkg::cmd_t data_i,
  input  logic          pop_i,
  output sss_pkg::cmd_t data_o,
  output logic          full_o,
  output logic          empty_o
);
  import sss_pkg::*;

  cmd_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

@@ src/sss_back.sv @@
// back end: state update sequencer over one shared multiplier, result register
module sss_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sss_pkg::cfg_t cfg_i,
  input  sss_pkg::cmd_t cmd_i,
  input  logic          cmd_valid_i,
  output logic          cmd_pop_o,
  input  logic          res_pop_i,
  output logic          res_empty_o,
  output sss_pkg::res_t res_o
);
  import sss_pkg::*;

  seq_e state_q, state_d;
  logic [31:0] energy_q, energy_d, memory_q, memory_d, stab_q, stab_d, steps_q, steps_d;
  logic [31:0] phi_q, phi_d, mem_q, mem_d;
  logic [39:0] t_q, t_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic [15:0] dt_q, dt_d;
  logic [NormW-1:0] norm_q, norm_d;
  logic [63:0] p_q, prod;
  logic [31:0] ma, mb, diff, kn;
  logic        kge, out_free, ov_q, ov_d;
  res_t        res_q, res_d;

  function automatic logic [31:0] sat32(input logic [AccW-1:0] a);
    if (a[AccW-1]) return 32'd0;
    if (|a[AccW-2:32]) return 32'hFFFF_FFFF;
    return a[31:0];
  endfunction

  function automatic res_t mk_res(input event_e ev, input logic [31:0] e, input logic [31:0] m,
                                  input logic [31:0] s, input logic [31:0] n);
    res_t r;
    r.ev        = ev;
    r.energy    = e;
    r.memory    = m;
    r.stability = s;
    r.steps     = n;
    r.terminal  = (s == 32'd0);
    return r;
  endfunction

  assign prod     = 64'(ma) * 64'(mb);
  assign kge      = cfg_i.kmax >= stab_q;
  assign diff     = kge ? cfg_i.kmax - stab_q : stab_q - cfg_i.kmax;
  assign out_free = ~ov_q | res_pop_i;
  assign kn       = acc_q[AccW-1] ? 32'd0 :
                    (acc_q[AccW-2:0] > (AccW-1)'(cfg_i.kmax)) ? cfg_i.kmax : acc_q[31:0];

  always_comb begin
    state_d   = state_q;
    energy_d  = energy_q;
    memory_d  = memory_q;
    stab_d    = stab_q;
    steps_d   = steps_q;
    phi_d     = phi_q;
    mem_d     = mem_q;
    t_d       = t_q;
    acc_d     = acc_q;
    dt_d      = dt_q;
    norm_d    = norm_q;
    ma        = '0;
    mb        = '0;
    cmd_pop_o = 1'b0;
    ov_d      = ov_q & ~res_pop_i;
    res_d     = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          ov_d      = 1'b1;
          if (cmd_i.is_load) begin
            if (cmd_i.load_stability > cfg_i.kmax) begin
              res_d = mk_res(EV_ERROR, energy_q, memory_q, stab_q, steps_q);
            end else begin
              energy_d = cmd_i.load_energy;
              memory_d = cmd_i.load_memory;
              stab_d   = cmd_i.load_stability;
              steps_d  = '0;
              res_d    = mk_res(EV_NORMAL, cmd_i.load_energy, cmd_i.load_memory,
                                cmd_i.load_stability, 32'd0);
            end
          end else if (stab_q == 32'd0) begin
            res_d = mk_res(EV_NORMAL, energy_q, memory_q, stab_q, steps_q);
          end else if (cmd_i.bad_count || cmd_i.dt == 16'd0) begin
            res_d = mk_res(EV_ERROR, energy_q, memory_q, stab_q, steps_q);
          end else begin
            ov_d    = ov_q & ~res_pop_i;
            dt_d    = cmd_i.dt;
            norm_d  = cmd_i.norm2;
            state_d = ST_C0;
          end
        end
      end
      ST_C0: begin
        ma = 32'(cfg_i.eta); mb = 32'(dt_q); state_d = ST_C1;
      end
      ST_C1: begin
        ma = energy_q; mb = p_q[31:0]; state_d = ST_C2;
      end
      ST_C2: begin
        acc_d = AccW'(energy_q) - AccW'(p_q[63:32]);
        ma = 32'(cfg_i.alpha); mb = norm_q[31:0]; state_d = ST_C3;
      end
      ST_C3: begin
        acc_d = acc_q + AccW'(p_q[63:16]);
        ma = 32'(cfg_i.alpha); mb = 32'(norm_q[NormW-1:32]); state_d = ST_C4;
      end
      ST_C4: begin
        acc_d = acc_q + AccW'({p_q[33:0], 16'd0});
        ma = 32'(cfg_i.beta); mb = 32'(dt_q); state_d = ST_C5;
      end
      ST_C5: begin
        phi_d = sat32(acc_q); t_d = p_q[39:0]; state_d = ST_C6;
      end
      ST_C6: begin
        ma = phi_q; mb = t_q[31:0]; state_d = ST_C7;
      end
      ST_C7: begin
        acc_d = AccW'(memory_q) + AccW'(p_q[63:32]);
        ma = phi_q; mb = 32'(t_q[39:32]); state_d = ST_C8;
      end
      ST_C8: begin
        acc_d = acc_q + AccW'(p_q[39:0]);
        ma = 32'(cfg_i.gamma); mb = 32'(dt_q); state_d = ST_C9;
      end
      ST_C9: begin
        ma = memory_q; mb = p_q[31:0]; state_d = ST_C10;
      end
      ST_C10: begin
        acc_d = acc_q - AccW'(p_q[63:32]);
        ma = 32'(cfg_i.rho); mb = 32'(dt_q); state_d = ST_C11;
      end
      ST_C11: begin
        mem_d = sat32(acc_q); t_d = p_q[39:0]; state_d = ST_C12;
      end
      ST_C12: begin
        ma = diff; mb = t_q[31:0]; state_d = ST_C13;
      end
      ST_C13: begin
        acc_d = kge ? AccW'(stab_q) + AccW'(p_q[63:32]) : AccW'(stab_q) - AccW'(p_q[63:32]);
        ma = 32'(cfg_i.lphi); mb = 32'(dt_q); state_d = ST_C14;
      end
      ST_C14: begin
        ma = phi_q; mb = p_q[31:0]; state_d = ST_C15;
      end
      ST_C15: begin
        acc_d = acc_q - AccW'(p_q[63:32]);
        ma = 32'(cfg_i.lm); mb = 32'(dt_q); state_d = ST_C16;
      end
      ST_C16: begin
        ma = mem_q; mb = p_q[31:0]; state_d = ST_C17;
      end
      ST_C17: begin
        acc_d = acc_q - AccW'(p_q[63:32]); state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          energy_d = phi_q;
          memory_d = mem_q;
          stab_d   = kn;
          steps_d  = (steps_q == 32'hFFFF_FFFF) ? steps_q : steps_q + 32'd1;
          ov_d     = 1'b1;
          res_d    = mk_res((kn == 32'd0) ? EV_COLLAPSE : EV_NORMAL, phi_q, mem_q, kn, steps_d);
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign res_empty_o = ~ov_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i) begin
    p_q    <= prod;
    phi_q  <= phi_d;
    mem_q  <= mem_d;
    t_q    <= t_d;
    acc_q  <= acc_d;
    dt_q   <= dt_d;
    norm_q <= norm_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      energy_q <= '0;
      memory_q <= '0;
      stab_q   <= '0;
      steps_q  <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      energy_q <= energy_d;
      memory_q <= memory_d;
      stab_q   <= stab_d;
      steps_q  <= steps_d;
      ov_q     <= ov_d;
    end
  end

endmodule

@@ tb/tb.sv @@
// testbench for structural_state_step: stimulus, state-step predictor and result checking
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sss_pkg::*;

  localparam int VecLen = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        push = 1'b0;
  logic        full;
  logic        operation_i = 1'b0;
  logic signed [15:0] delta_value_i = '0;
  logic        last_element_i = 1'b0;
  logic [15:0] time_step_i = '0;
  logic [31:0] load_energy_i = '0, load_memory_i = '0, load_stability_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  event_res_o;
  logic [31:0] energy_out_o, memory_out_o, stability_out_o, steps_done_o;
  logic        terminal_flag_o;

  structural_state_step #(.VECTOR_LEN(VecLen), .DELTA_LIMIT(0)) u_top (.*);

  always #5ns clk_i = ~clk_i;

  // predictor state
  cfg_t        cfg;
  logic [31:0] energy_q, memory_q, stab_q, steps_q;
  logic [47:0] norm_acc;
  logic [7:0]  elem_cnt;
  logic        elem_ovf;

  res_t expected_results[$];
  int   errors = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;

  function automatic logic [63:0] mul_sh32(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return 64'(p >> 32);
  endfunction

  function automatic logic [31:0] sat32(logic [63:0] x);
    return (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
  endfunction

  function automatic res_t snapshot(event_e ev);
    res_t r;
    r.ev        = ev;
    r.energy    = energy_q;
    r.memory    = memory_q;
    r.stability = stab_q;
    r.steps     = steps_q;
    r.terminal  = (stab_q == 0);
    return r;
  endfunction

  task automatic clear_sum();
    norm_acc = '0;
    elem_cnt = '0;
    elem_ovf = 1'b0;
  endtask

  task automatic model_reset();
    cfg = '{alpha: 24'd65536, beta: 24'd65536, eta: 16'd655, gamma: 16'd655,
            rho: 16'd655, lphi: 16'd655, lm: 16'd655, kmax: 32'd65536};
    energy_q = '0;
    memory_q = '0;
    stab_q   = '0;
    steps_q  = '0;
    clear_sum();
  endtask

  // state update for one accepted item
  task automatic predict_transfer();
    logic [63:0] dt, norm2, phi_n, mem_n, mr;
    longint      k;
    logic [31:0] kn;
    logic signed [31:0] v;
    logic        bad;
    dt = 64'(time_step_i);
    if (operation_i) begin
      clear_sum();
      if (load_stability_i > cfg.kmax) begin
        expected_results.push_back(snapshot(EV_ERROR));
      end else begin
        energy_q = load_energy_i;
        memory_q = load_memory_i;
        stab_q   = load_stability_i;
        steps_q  = '0;
        expected_results.push_back(snapshot(EV_NORMAL));
      end
      return;
    end
    v = 32'(delta_value_i);
    norm_acc = norm_acc + 48'(32'(v * v));
    if (elem_cnt == 8'd255) elem_ovf = 1'b1;
    else elem_cnt++;
    if (!last_element_i) return;
    norm2 = 64'(norm_acc);
    bad = elem_ovf || (elem_cnt != VecLen);
    clear_sum();
    if (stab_q == 0) begin
      expected_results.push_back(snapshot(EV_NORMAL));
      return;
    end
    mr = 64'(cfg.eta);
    if (cfg.gamma > mr) mr = 64'(cfg.gamma);
    if (cfg.rho > mr) mr = 64'(cfg.rho);
    if (cfg.lphi > mr) mr = 64'(cfg.lphi);
    if (cfg.lm > mr) mr = 64'(cfg.lm);
    if (bad || dt == 0 || dt * mr >= 64'h1_0000_0000) begin
      expected_results.push_back(snapshot(EV_ERROR));
      return;
    end
    phi_n = sat32(64'(energy_q) + ((64'(cfg.alpha) * norm2) >> 16)
                  - mul_sh32(energy_q, cfg.eta * dt));
    mem_n = sat32(64'(memory_q) + mul_sh32(phi_n, cfg.beta * dt)
                  - mul_sh32(memory_q, cfg.gamma * dt));
    k = longint'(stab_q);
    if (cfg.kmax >= stab_q) k += longint'(mul_sh32(cfg.kmax - stab_q, cfg.rho * dt));
    else k -= longint'(mul_sh32(stab_q - cfg.kmax, cfg.rho * dt));
    k -= longint'(mul_sh32(phi_n, cfg.lphi * dt));
    k -= longint'(mul_sh32(mem_n, cfg.lm * dt));
    if (k < 0) kn = '0;
    else if (k > longint'(cfg.kmax)) kn = cfg.kmax;
    else kn = 32'(k);
    energy_q = phi_n[31:0];
    memory_q = mem_n[31:0];
    if (steps_q != 32'hFFFF_FFFF) steps_q++;
    if (kn == 0) begin
      stab_q = kn;
      expected_results.push_back(snapshot(EV_COLLAPSE));
    end else begin
      stab_q = kn;
      expected_results.push_back(snapshot(EV_NORMAL));
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result checking
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(event_res_o), 32'hx);
      end else begin
        want = expected_results.pop_front();
        if (event_res_o != want.ev)
          report_mismatch("event", 32'(event_res_o), 32'(want.ev));
        if (energy_out_o != want.energy) report_mismatch("energy", energy_out_o, want.energy);
        if (memory_out_o != want.memory) report_mismatch("memory", memory_out_o, want.memory);
        if (stability_out_o != want.stability)
          report_mismatch("stability", stability_out_o, want.stability);
        if (steps_done_o != want.steps) report_mismatch("steps", steps_done_o, want.steps);
        if (terminal_flag_o != want.terminal)
          report_mismatch("terminal", 32'(terminal_flag_o), 32'(want.terminal));
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_item(logic op, logic [15:0] delta, logic last, logic [15:0] dt,
                           logic [31:0] le = '0, logic [31:0] lm = '0, logic [31:0] ls = '0);
    if ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    operation_i      = op;
    delta_value_i    = delta;
    last_element_i   = last;
    time_step_i      = dt;
    load_energy_i    = le;
    load_memory_i    = lm;
    load_stability_i = ls;
    push             = 1'b1;
    do @(posedge clk_i); while (full);
    predict_transfer();
    @(negedge clk_i);
  endtask

  task automatic send_load(logic [31:0] le, logic [31:0] lm, logic [31:0] ls);
    send_item(1'b1, 16'($urandom()), 1'($urandom()), 16'($urandom()), le, lm, ls);
  endtask

  // n elements, the last one marked; delta magnitude bounded by mag
  task automatic send_step(int n, logic [15:0] dt, int mag = 32767);
    for (int i = 0; i < n; i++)
      send_item(1'b0, 16'($signed($urandom_range(2 * mag)) - mag), i == n - 1, dt);
  endtask

  task automatic drain();
    push = 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    case (idx)
      CFG_ENERGY_GAIN:   cfg.alpha = val[23:0];
      CFG_MEMORY_GAIN:   cfg.beta  = val[23:0];
      CFG_ENERGY_DECAY:  cfg.eta   = val[15:0];
      CFG_MEMORY_DECAY:  cfg.gamma = val[15:0];
      CFG_RECOVERY_RATE: cfg.rho   = val[15:0];
      CFG_ENERGY_STRESS: cfg.lphi  = val[15:0];
      CFG_MEMORY_STRESS: cfg.lm    = val[15:0];
      default:           cfg.kmax  = val;
    endcase
  endtask

  task automatic write_all(logic [23:0] a, logic [23:0] b, logic [15:0] e, logic [15:0] g,
                           logic [15:0] r, logic [15:0] p, logic [15:0] m, logic [31:0] k);
    drain();
    write_reg(CFG_ENERGY_GAIN, 32'(a));
    write_reg(CFG_MEMORY_GAIN, 32'(b));
    write_reg(CFG_ENERGY_DECAY, 32'(e));
    write_reg(CFG_MEMORY_DECAY, 32'(g));
    write_reg(CFG_RECOVERY_RATE, 32'(r));
    write_reg(CFG_ENERGY_STRESS, 32'(p));
    write_reg(CFG_MEMORY_STRESS, 32'(m));
    write_reg(CFG_STABILITY_MAX, k);
  endtask

  task automatic test_directed();
    send_step(VecLen, 16'd1000);
    send_load(32'h1_0000, 32'h8000, 32'h1_0001);
    send_load(32'h1_0000, 32'h8000, 32'h1_0000);
    send_item(1'b0, 16'h7FFF, 1'b0, 16'd0);
    send_item(1'b0, 16'h8000, 1'b0, 16'd0);
    send_item(1'b0, 16'hFFFF, 1'b0, 16'd0);
    send_item(1'b0, 16'h0000, 1'b0, 16'd0);
    send_item(1'b0, 16'h5555, 1'b0, 16'd0);
    send_item(1'b0, 16'hAAAA, 1'b0, 16'd0);
    send_item(1'b0, 16'h0001, 1'b0, 16'd0);
    send_item(1'b0, 16'h8001, 1'b1, 16'hFFFF);
    send_step(VecLen, 16'd0, 100);
    send_step(VecLen - 1, 16'd500, 100);
    send_item(1'b0, 16'h0100, 1'b0, 16'd0);
    send_load(32'h20, 32'h10, 32'h100);
  endtask

  task automatic test_count_overflow();
    send_load(32'h0, 32'h0, 32'h8000);
    for (int i = 0; i < 257; i++) send_item(1'b0, 16'h0080, i == 256, 16'd100);
    send_step(VecLen + 1, 16'd100, 50);
    send_step(VecLen, 16'd100, 50);
  endtask

  task automatic test_collapse();
    write_all(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              32'hFFFF_FFFF);
    send_load(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_step(VecLen, 16'hFFFF);
    send_step(VecLen, 16'hFFFF);
    send_load(32'h1_0000, 32'h0, 32'h8000_0000);
    send_step(VecLen, 16'h0001);
    drain();
    write_reg(CFG_STABILITY_MAX, 32'h1000);
    send_load(32'h0, 32'h0, 32'h1000);
    send_step(VecLen, 16'h8000, 10);
    write_all(24'd1, 24'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 32'd1);
    send_load(32'h5, 32'h5, 32'h1);
    send_step(VecLen, 16'hFFFF);
    send_step(VecLen, 16'h1);
  endtask

  task automatic test_random(int count);
    int   sent = 0;
    int   kind;
    int   mag;
    while (sent < count) begin
      kind = $urandom_range(99);
      mag = ($urandom_range(3) == 0) ? 32767 : $urandom_range(1, 2000);
      if (kind < 8) begin
        send_load($urandom_range(3) == 0 ? $urandom() : $urandom_range(32'h4_0000),
                  $urandom_range(3) == 0 ? $urandom() : $urandom_range(32'h4_0000),
                  $urandom_range(9) == 0 ? $urandom() : $urandom_range(cfg.kmax));
        sent++;
      end else if (kind < 14) begin
        send_step($urandom_range(1, 12), 16'($urandom()), mag);
        sent += 6;
      end else if (kind < 17) begin
        send_step(VecLen, 16'd0, mag);
        sent += VecLen;
      end else begin
        if (stab_q == 0) send_load($urandom_range(32'h2_0000), $urandom_range(32'h2_0000),
                                   $urandom_range(1, cfg.kmax));
        send_step(VecLen,
                  16'(($urandom_range(3) == 0) ? $urandom() : $urandom_range(1, 4000)),
                  mag);
        sent += VecLen;
      end
    end
  endtask

  task automatic test_config_random();
    write_all(24'($urandom_range(1, 24'h40000)), 24'($urandom_range(1, 24'h20000)),
              16'($urandom_range(1, 4000)), 16'($urandom_range(1, 4000)),
              16'($urandom_range(1, 65535)),
              16'($urandom_range(1, 3000)), 16'($urandom_range(1, 3000)),
              $urandom_range(32'h1000, 32'h10_0000));
  endtask

  initial begin
    model_reset();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    send_idle_pct = 37;
    recv_idle_pct = 54;
    test_directed();
    test_count_overflow();
    test_collapse();
    write_all(24'd65536, 24'd65536, 16'd655, 16'd655, 16'd655, 16'd655, 16'd655, 32'd65536);
    test_random(30);
    send_idle_pct = 54;
    recv_idle_pct = 37;
    test_config_random();
    test_random(30);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_config_random();
    test_random(30);
    drain();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
